[hw/rtl/bpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Sizes, field widths, codes and the command and status groups that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Geometry of the page bitmap.
  localparam int unsigned MAX_PAGES  = 65536;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned WORD_BITS  = 32;

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int unsigned WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WORD_IDX_W = $clog2(WORD_COUNT);
  localparam int unsigned PAGE_IDX_W = WORD_IDX_W + BIT_IDX_W;
  localparam int unsigned PCNT_W     = PAGE_IDX_W + 1;

  // Request and response fields.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned LEN_W      = 48;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned FREE_W     = 17;
  localparam int unsigned TOTAL_W    = 17;
  localparam int unsigned PG_ADDR_W  = ADDR_W - PAGE_SHIFT;

  localparam int unsigned IN_DATA_W  = ((OP_W + ADDR_W + LEN_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((STATUS_W + ADDR_W + FREE_W + 7) / 8) * 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(65536);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC     = 2'd0,
    OP_FREE      = 2'd1,
    OP_MARK_FREE = 2'd2,
    OP_MARK_USED = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_REJECT  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_PAGES = 1'd0,
    CFG_BASE_OFFSET = 1'd1
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic setup;
    logic scan_rd;
    logic scan_chk;
    logic mod_rd;
    logic mod_wr;
    logic respond;
  } bpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic start_scan;
    logic start_mod;
    logic scan_done;
    logic mod_last;
    logic out_busy;
  } bpa_stat_t;

endpackage

[hw/rtl/bpa_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator datapath
// Holds the used-page bitmap memory, the free count, the configuration, the
// request registers, the scan and range cursors and the response register.
// ----------------------------------------------------------------------------
module bpa_datapath import bpa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bpa_cmd_t              cmd_i,
  output bpa_stat_t             stat_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic                  m_tready_i,
  output logic                  m_tvalid_o,
  output logic [OUT_DATA_W-1:0] m_tdata_o
);

  logic [WORD_BITS-1:0]  bitmap_mem [WORD_COUNT];
  logic [WORD_BITS-1:0]  rdata_q;

  logic [TOTAL_W-1:0]    total_q;
  logic [ADDR_W-1:0]     base_q;
  logic [PCNT_W-1:0]     count_q, count_d;
  logic [WORD_IDX_W-1:0] clr_q;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  op_e                   op_q;
  logic [PG_ADDR_W-1:0]  page_q;
  logic [PG_ADDR_W:0]    end_q;
  logic [PCNT_W-1:0]     lim_q;
  logic [WORD_IDX_W:0]   word_q, word_end_q;
  logic [PCNT_W-1:0]     cursor_q, pend_q;
  status_e               status_q;
  logic [PAGE_IDX_W-1:0] alloc_pg_q;

  // Request fields.
  op_e                   in_op;
  logic [ADDR_W-1:0]     in_addr;
  logic [LEN_W-1:0]      in_len;
  logic [ADDR_W-1:0]     addr_strip;
  logic [PG_ADDR_W-1:0]  page_sel;
  logic [PG_ADDR_W:0]    end_sum;

  assign in_op      = op_e'(s_tdata_i[OP_W-1:0]);
  assign in_addr    = s_tdata_i[OP_W +: ADDR_W];
  assign in_len     = s_tdata_i[OP_W + ADDR_W +: LEN_W];
  assign addr_strip = (in_addr >= base_q) ? in_addr - base_q : in_addr;
  assign page_sel   = (in_op == OP_FREE) ? addr_strip[ADDR_W-1:PAGE_SHIFT]
                                         : in_addr[ADDR_W-1:PAGE_SHIFT];
  assign end_sum    = {1'b0, in_addr[ADDR_W-1:PAGE_SHIFT]}
                    + (PG_ADDR_W+1)'(in_len[LEN_W-1:PAGE_SHIFT]);

  // Setup decisions.
  logic [PCNT_W-1:0]   lim_c;
  logic [WORD_IDX_W:0] word_end_c;
  logic                free_reject, range_empty, is_range;
  logic [PCNT_W-1:0]   pend_c;

  always_comb begin
    if (32'(total_q) > MAX_PAGES) begin
      lim_c = PCNT_W'(MAX_PAGES);
    end else begin
      lim_c = PCNT_W'(total_q);
    end
  end

  assign word_end_c  = (WORD_IDX_W+1)'(({1'b0, lim_c} + (PCNT_W+1)'(WORD_BITS - 1))
                                       >> BIT_IDX_W);
  assign free_reject = (page_q == '0) || (page_q >= PG_ADDR_W'(lim_c));
  assign range_empty = (page_q >= PG_ADDR_W'(lim_c)) || ({1'b0, page_q} >= end_q);
  assign is_range    = (op_q == OP_MARK_FREE) || (op_q == OP_MARK_USED);

  always_comb begin
    if (op_q == OP_FREE) begin
      pend_c = page_q[PCNT_W-1:0] + 1'b1;
    end else if (end_q >= (PG_ADDR_W+1)'(lim_c)) begin
      pend_c = lim_c;
    end else begin
      pend_c = end_q[PCNT_W-1:0];
    end
  end

  // First-fit search over one bitmap word. Page 0 and pages beyond the
  // tracked limit are treated as used.
  logic                 scan_last, scan_hit;
  logic [WORD_BITS-1:0] tail_mask, zero_mask, avail, onehot;
  logic [BIT_IDX_W-1:0] hit_bit;

  assign scan_last = (word_q + 1'b1) == word_end_q;
  assign tail_mask = (scan_last && (lim_q[BIT_IDX_W-1:0] != '0))
                   ? ~((WORD_BITS'(1) << lim_q[BIT_IDX_W-1:0]) - WORD_BITS'(1)) : '0;
  assign zero_mask = (word_q == '0) ? WORD_BITS'(1) : '0;
  assign avail     = ~(rdata_q | tail_mask | zero_mask);
  assign scan_hit  = |avail;
  assign onehot    = avail & (~avail + WORD_BITS'(1));

  always_comb begin
    hit_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        hit_bit = BIT_IDX_W'(i);
      end
    end
  end

  // Single-page read-modify-write for frees and range marks.
  logic [WORD_IDX_W-1:0] mod_word;
  logic [BIT_IDX_W-1:0]  mod_bit;
  logic [WORD_BITS-1:0]  bit_mask;
  logic                  cur_used, mark_used, mod_last;

  assign mod_word  = cursor_q[PAGE_IDX_W-1:BIT_IDX_W];
  assign mod_bit   = cursor_q[BIT_IDX_W-1:0];
  assign bit_mask  = WORD_BITS'(1) << mod_bit;
  assign cur_used  = rdata_q[mod_bit];
  assign mark_used = (op_q == OP_MARK_USED);
  assign mod_last  = (cursor_q + 1'b1) >= pend_q;

  // Memory port selection.
  logic                  mem_we, mem_re;
  logic [WORD_IDX_W-1:0] waddr, raddr;
  logic [WORD_BITS-1:0]  wdata;

  always_comb begin
    mem_we = 1'b0;
    waddr  = clr_q;
    wdata  = '1;
    if (cmd_i.clear_step) begin
      mem_we = 1'b1;
    end else if (cmd_i.scan_chk && scan_hit) begin
      mem_we = 1'b1;
      waddr  = word_q[WORD_IDX_W-1:0];
      wdata  = rdata_q | onehot;
    end else if (cmd_i.mod_wr) begin
      mem_we = 1'b1;
      waddr  = mod_word;
      wdata  = mark_used ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
    end
  end

  assign mem_re = cmd_i.scan_rd || cmd_i.mod_rd;
  assign raddr  = cmd_i.scan_rd ? word_q[WORD_IDX_W-1:0] : mod_word;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= bitmap_mem[raddr];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.scan_chk && scan_hit) begin
      count_d = count_q - 1'b1;
    end else if (cmd_i.mod_wr) begin
      if (mark_used && !cur_used) begin
        count_d = count_q - 1'b1;
      end else if (!mark_used && cur_used) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  logic [ADDR_W-1:0] page_addr;

  assign page_addr = ((op_q == OP_ALLOC) && (status_q == ST_OK))
                   ? (ADDR_W'(alloc_pg_q) << PAGE_SHIFT) + base_q : '0;

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= TOTAL_RESET;
      base_q      <= '0;
      count_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_TOTAL_PAGES: total_q <= cfg_data_i[TOTAL_W-1:0];
          CFG_BASE_OFFSET: base_q  <= cfg_data_i[ADDR_W-1:0];
          default: ;
        endcase
      end
      count_q <= count_d;
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.respond) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, cursor and response payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= in_op;
      page_q <= page_sel;
      end_q  <= end_sum;
    end
    if (cmd_i.setup) begin
      lim_q      <= lim_c;
      word_end_q <= word_end_c;
      word_q     <= '0;
      cursor_q   <= page_q[PCNT_W-1:0];
      pend_q     <= pend_c;
      if (op_q == OP_ALLOC) begin
        status_q <= ST_NO_FREE;
      end else if ((op_q == OP_FREE) && free_reject) begin
        status_q <= ST_REJECT;
      end else begin
        status_q <= ST_OK;
      end
    end
    if (cmd_i.scan_chk) begin
      word_q <= word_q + 1'b1;
      if (scan_hit) begin
        status_q   <= ST_OK;
        alloc_pg_q <= {word_q[WORD_IDX_W-1:0], hit_bit};
      end
    end
    if (cmd_i.mod_wr) begin
      cursor_q <= cursor_q + 1'b1;
    end
    if (cmd_i.respond) begin
      out_data_q <= OUT_DATA_W'({FREE_W'(count_q), page_addr, status_q});
    end
  end

  assign stat_o.clear_done = (clr_q == WORD_IDX_W'(WORD_COUNT - 1));
  assign stat_o.start_scan = (op_q == OP_ALLOC) && (count_q != '0) && (word_end_c != '0);
  assign stat_o.start_mod  = ((op_q == OP_FREE) && !free_reject) || (is_range && !range_empty);
  assign stat_o.scan_done  = scan_hit || scan_last;
  assign stat_o.mod_last   = mod_last;
  assign stat_o.out_busy   = out_valid_q && !m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

[hw/rtl/bpa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator controller
// Sequences the clearing pass, request setup, word scan, page updates and
// the hand-off of each response to the output register.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  input  bpa_stat_t stat_i,
  output bpa_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MOD_RD,
    S_MOD_WR,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid_i && ready_q) begin
          cmd_o.accept = 1'b1;
          state_d      = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        if (stat_i.start_scan) begin
          state_d = S_SCAN_RD;
        end else if (stat_i.start_mod) begin
          state_d = S_MOD_RD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd_o.scan_chk = 1'b1;
        state_d        = stat_i.scan_done ? S_RESP : S_SCAN_RD;
      end
      S_MOD_RD: begin
        cmd_o.mod_rd = 1'b1;
        state_d      = S_MOD_WR;
      end
      S_MOD_WR: begin
        cmd_o.mod_wr = 1'b1;
        state_d      = stat_i.mod_last ? S_RESP : S_MOD_RD;
      end
      S_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == S_IDLE);
    end
  end

  assign s_tready_o = ready_q;

endmodule

[hw/rtl/bitmap_page_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator
// First-fit physical page allocator with one used bit per page and a count
// of free pages.
// ----------------------------------------------------------------------------
// Usage: each request taken on the s_axis channel yields exactly one response
// on the m_axis channel. A request is allocate, free one page, or mark a byte
// range free or used. The user writes total_pages and base_offset through the
// cfg port only while no request is in flight; the block does not check it.
//
// Sequence: the block works on one request at a time. After the accept there
// is a setup state, then the work, then a response state that loads the
// output register once it can take the response. An allocation scans the
// bitmap memory word by word, reading each word and then checking and
// updating it, and visits at most 2048 words. A free reads and rewrites its
// one page unless it is rejected, and a range mark does so in turn for each
// of its pages inside the tracked range. The single read port and the
// read-modify-write of each word set this order of steps.
//
// Reset: the bitmap is swept to all ones (every page used), one word per
// cycle, over 2048 words; s_axis_tready stays low until the sweep is done.
// The free count resets to zero. Configuration writes are taken at any time.
//
// Backpressure: a finished response waits in the output register while the
// next request is accepted; that request's response is held back until the
// register has been drained.
// ----------------------------------------------------------------------------
module bitmap_page_allocator import bpa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // From the lowest bit: operation[1:0], address[65:2], range_length[113:66].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // From the lowest bit: status[1:0], page_address[65:2], free_pages[82:66].
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  bpa_cmd_t  cmd;
  bpa_stat_t stat;

  // The controller only sequences; every register that holds data lives in
  // the datapath, including the bitmap memory.
  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bpa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule

[hw/rtl/bpa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator checker
// Port-level properties of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bpa_checker import bpa_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [STATUS_W-1:0] rsp_status;
  logic [ADDR_W-1:0]   rsp_addr;
  logic [FREE_W-1:0]   rsp_free;

  assign rsp_status = m_axis_tdata[STATUS_W-1:0];
  assign rsp_addr   = m_axis_tdata[STATUS_W +: ADDR_W];
  assign rsp_free   = m_axis_tdata[STATUS_W + ADDR_W +: FREE_W];

  // A stalled response stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("response changed while stalled");

  // Requests are handled one at a time: no accept right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in setup");

  // Only a successful allocation carries an address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (rsp_status != ST_OK) |-> rsp_addr == '0)
    else $error("failed request returned a page address");

  // The status code and the free count stay in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (rsp_status <= ST_REJECT) && (rsp_free <= FREE_W'(MAX_PAGES)))
    else $error("response status or free count out of range");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/tb_bitmap_page_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives allocate, free and range-mark requests into the allocator through a
// randomly idling stream driver. It predicts every response with its own copy
// of the page bitmap, free count and registers, and checks each response field
// by field as it leaves under random backpressure.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator;
  import bpa_pkg::*;

  // A request as the driver sees it, and the response the predictor expects.
  typedef struct {
    op_e             op;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  range_len;
  } page_req_t;

  typedef struct {
    status_e           status;
    logic [ADDR_W-1:0] page_address;
    logic [FREE_W-1:0] free_pages;
  } page_resp_t;

  // The longest single request the block can take is a range mark over all
  // 65536 pages. The stimulus stays far below that, but the limit covers it,
  // plus the long receiver hold, about twice over.
  localparam int unsigned STALL_LIMIT  = 300000;
  // Cycles the receiver refuses responses during a pressure stretch.
  localparam int unsigned HOLD_CYCLES  = 400;
  // Percentage of cycles in which either side idles.
  localparam int unsigned IDLE_PCT     = 28;
  // Requests and responses in this window are moved with no idling at all.
  localparam int unsigned QUIET_FIRST  = 600;
  localparam int unsigned QUIET_LAST   = 900;
  // Cycles allowed after the last response for anything unexpected to appear.
  localparam int unsigned TAIL_CYCLES  = 50;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // From the lowest bit: operation[1:0], address[65:2], range_length[113:66].
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // From the lowest bit: status[1:0], page_address[65:2], free_pages[82:66].
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  bitmap_page_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor state: the testbench's own copy of the bitmap, the free count
  // and both registers. A set bit means the page is in use.
  // --------------------------------------------------------------------------
  bit   [WORD_BITS-1:0] page_map [WORD_COUNT];
  logic [PCNT_W-1:0]    free_cnt;
  logic [TOTAL_W-1:0]   total_cfg;
  logic [ADDR_W-1:0]    base_cfg;

  page_req_t  page_reqs[$];       // requests waiting for the driver
  page_resp_t expected_resps[$];  // predicted responses, oldest first

  int unsigned mismatch_cnt = 0;

  // Values of total_pages above the bitmap size behave as the bitmap size.
  function automatic longint unsigned tracked_pages();
    return (total_cfg > MAX_PAGES) ? longint'(MAX_PAGES) : longint'(total_cfg);
  endfunction

  function automatic bit page_used(longint unsigned pg);
    return page_map[pg / WORD_BITS][pg % WORD_BITS];
  endfunction

  // Moving a page to the state it already holds leaves the count alone, and
  // pages outside the tracked range are never touched.
  function automatic void set_page(longint unsigned pg, bit used);
    if (pg >= tracked_pages())
      return;
    if (used && !page_used(pg)) begin
      page_map[pg / WORD_BITS][pg % WORD_BITS] = 1'b1;
      free_cnt--;
    end else if (!used && page_used(pg)) begin
      page_map[pg / WORD_BITS][pg % WORD_BITS] = 1'b0;
      free_cnt++;
    end
  endfunction

  // A range covers length / page size whole pages from the page holding the
  // start address. Pages at or past the tracked limit are dropped.
  function automatic void mark_pages(logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len,
                                     bit used);
    longint unsigned first_pg;
    longint unsigned stop_pg;
    first_pg = addr >> PAGE_SHIFT;
    stop_pg  = first_pg + (64'(len) >> PAGE_SHIFT);
    if (stop_pg > tracked_pages())
      stop_pg = tracked_pages();
    for (longint unsigned pg = first_pg; pg < stop_pg; pg++)
      set_page(pg, used);
  endfunction

  // Works out the response to one accepted request and updates the copy of
  // the bitmap the way the block must.
  function automatic page_resp_t predict_resp(page_req_t r);
    page_resp_t      resp;
    longint unsigned lim;
    longint unsigned pg;
    longint unsigned hit;
    logic [ADDR_W-1:0] stripped;
    bit              stop;
    resp.status       = ST_OK;
    resp.page_address = '0;
    lim  = tracked_pages();
    hit  = 0;
    stop = 1'b0;
    case (r.op)
      OP_ALLOC: begin
        // First fit: full words are skipped, page 0 is never handed out, and
        // the scan ends at the tracked limit.
        if (free_cnt != 0) begin
          for (longint unsigned w = 0; w < (lim + 31) / WORD_BITS && !stop; w++) begin
            if (page_map[w] != '1) begin
              for (int unsigned b = 0; b < WORD_BITS && !stop; b++) begin
                pg = w * WORD_BITS + b;
                if (pg >= lim) begin
                  stop = 1'b1;
                end else if (pg != 0 && !page_used(pg)) begin
                  hit  = pg;
                  stop = 1'b1;
                end
              end
            end
          end
        end
        if (hit == 0) begin
          resp.status = ST_NO_FREE;
        end else begin
          set_page(hit, 1'b1);
          resp.page_address = (64'(hit) << PAGE_SHIFT) + base_cfg;
        end
      end
      OP_FREE: begin
        // The base offset only comes off when the address is at or above it.
        stripped = r.address;
        if (stripped >= base_cfg)
          stripped = stripped - base_cfg;
        pg = stripped >> PAGE_SHIFT;
        if (pg == 0 || pg >= lim)
          resp.status = ST_REJECT;
        else
          set_page(pg, 1'b0);
      end
      OP_MARK_FREE: mark_pages(r.address, r.range_len, 1'b0);
      default:      mark_pages(r.address, r.range_len, 1'b1);
    endcase
    resp.free_pages = free_cnt;
    return resp;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. It offers the next pending request unless it decides to
  // idle this cycle, and holds tvalid and tdata steady until the request is
  // taken. The prediction is made at the edge where the request is accepted.
  // --------------------------------------------------------------------------
  page_req_t   cur_req;
  int unsigned sent_cnt = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_resps.push_back(predict_resp(cur_req));
        sent_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (page_reqs.size() != 0 &&
            ((sent_cnt >= QUIET_FIRST && sent_cnt < QUIET_LAST) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_req = page_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_DATA_W'({cur_req.range_len, cur_req.address, cur_req.op});
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response monitor and receiver. Every accepted response is compared with
  // the oldest prediction. Twice during the run the receiver refuses responses
  // for a long stretch while the driver keeps offering, so the block's output
  // register fills and it has to stall its input.
  // --------------------------------------------------------------------------
  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endtask

  int unsigned rcv_cnt      = 0;
  int unsigned hold_left    = 0;
  int unsigned next_hold_at = 300;

  always @(posedge clk_i) begin : resp_monitor
    page_resp_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        rcv_cnt++;
        if (expected_resps.size() == 0) begin
          note_mismatch("unexpected response", '0, m_axis_tdata[63:0]);
        end else begin
          want = expected_resps.pop_front();
          if (m_axis_tdata[STATUS_W-1:0] !== want.status)
            note_mismatch("status", want.status, m_axis_tdata[STATUS_W-1:0]);
          if (m_axis_tdata[STATUS_W +: ADDR_W] !== want.page_address)
            note_mismatch("page_address", want.page_address, m_axis_tdata[STATUS_W +: ADDR_W]);
          if (m_axis_tdata[STATUS_W + ADDR_W +: FREE_W] !== want.free_pages)
            note_mismatch("free_pages", want.free_pages,
                          m_axis_tdata[STATUS_W + ADDR_W +: FREE_W]);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rcv_cnt == next_hold_at) begin
        // Move the trigger on at once: the count does not change while held.
        hold_left     = HOLD_CYCLES;
        next_hold_at += 900;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (rcv_cnt >= QUIET_FIRST && rcv_cnt < QUIET_LAST) ||
                         ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: ends the run when no request and no response has moved for too
  // long. The clearing sweep after reset counts too, and is far shorter.
  int unsigned stall_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("tb_bitmap_page_allocator: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic queue_req(op_e op, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
    page_req_t r;
    r.op        = op;
    r.address   = addr;
    r.range_len = len;
    page_reqs.push_back(r);
  endtask

  // Every request yields exactly one response, so once nothing is pending,
  // offered or expected the block is idle and may be reconfigured. The check
  // is made between clock edges, after the driver's updates have settled, so
  // a request it has just picked up is always seen as offered.
  task automatic drain();
    @(negedge clk_i);
    while (page_reqs.size() != 0 || s_axis_tvalid || expected_resps.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TOTAL_PAGES)
      total_cfg = data[TOTAL_W-1:0];
    else
      base_cfg = data;
  endtask

  // One random phase: reconfigure while idle, then queue a mix of requests.
  // Most frees name a real tracked page; the rest hit page 0, fall below the
  // base offset or are plain noise. Ranges are mostly a few pages long inside
  // the tracked area, with some noise and some that run far past the end.
  task automatic run_phase(logic [TOTAL_W-1:0] total, logic [ADDR_W-1:0] base,
                           int unsigned count);
    longint unsigned   span;
    longint unsigned   pg;
    int unsigned       roll;
    int unsigned       kind;
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    drain();
    write_cfg(CFG_TOTAL_PAGES, CFG_DATA_W'(total));
    write_cfg(CFG_BASE_OFFSET, base);
    // Keep the touched pages low on a big bitmap so allocations and range
    // marks stay short.
    span = (tracked_pages() > 1024) ? 1024 : tracked_pages();
    repeat (count) begin
      roll = $urandom_range(0, 99);
      kind = $urandom_range(0, 99);
      op   = (roll < 35) ? OP_ALLOC : (roll < 65) ? OP_FREE :
             (roll < 85) ? OP_MARK_FREE : OP_MARK_USED;
      addr = {$urandom, $urandom};
      len  = LEN_W'({$urandom, $urandom});
      if (op == OP_FREE) begin
        if (kind < 70) begin
          pg   = $urandom_range(1, int'(span) - 1);
          addr = base_cfg + (64'(pg) << PAGE_SHIFT) + $urandom_range(0, PAGE_BYTES - 1);
        end else if (kind < 80) begin
          addr = base_cfg + $urandom_range(0, PAGE_BYTES - 1);
        end else if (kind < 90 && base_cfg != 0) begin
          addr = {$urandom, $urandom} % base_cfg;
        end
      end else if (op != OP_ALLOC) begin
        if (kind < 85 || (kind < 95 && tracked_pages() > 1024)) begin
          pg   = $urandom_range(0, int'(span) + 8);
          addr = (64'(pg) << PAGE_SHIFT) | $urandom_range(0, PAGE_BYTES - 1);
          len  = (LEN_W'($urandom_range(0, 40)) << PAGE_SHIFT) |
                 $urandom_range(0, PAGE_BYTES - 1);
        end else if (kind < 95) begin
          // Start inside, length so large that the range runs off the end.
          pg   = $urandom_range(0, int'(span) - 1);
          addr = (64'(pg) << PAGE_SHIFT) | $urandom_range(0, PAGE_BYTES - 1);
        end
      end
      queue_req(op, addr, len);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    foreach (page_map[i])
      page_map[i] = '1;
    free_cnt  = '0;
    total_cfg = TOTAL_RESET;
    base_cfg  = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset configuration: every page starts used.
    queue_req(OP_ALLOC, '0, '0);                         // nothing free at all
    queue_req(OP_FREE, '0, '0);                          // page 0 is rejected
    queue_req(OP_FREE, 64'h1000, '0);                    // page 1 freed
    queue_req(OP_FREE, 64'h1fff, '0);                    // already free
    queue_req(OP_ALLOC, '0, '0);                         // gets page 1 back
    queue_req(OP_MARK_FREE, '0, 48'h2064);               // pages 0 and 1
    queue_req(OP_ALLOC, '0, '0);                         // page 1, not page 0
    queue_req(OP_ALLOC, '0, '0);                         // only page 0 is left
    queue_req(OP_MARK_USED, '0, 48'h1000);               // page 0 used again
    queue_req(OP_MARK_FREE, 64'(65500) << PAGE_SHIFT,    // runs past the last page
              48'(100) << PAGE_SHIFT);
    queue_req(OP_ALLOC, '0, '0);                         // scans nearly all words
    queue_req(OP_FREE, 64'(MAX_PAGES) << PAGE_SHIFT, '0);  // beyond total_pages
    queue_req(OP_MARK_USED, '1, '1);                     // starts far past the end
    queue_req(OP_FREE, '1, '0);
    queue_req(OP_MARK_FREE, 64'h5000, '0);               // zero length, no pages

    // Nothing tracked, while free pages left above stay counted. The freed
    // address wraps past the top, stays below the offset and is not stripped.
    drain();
    write_cfg(CFG_TOTAL_PAGES, '0);
    write_cfg(CFG_BASE_OFFSET, 64'hffff_ffff_ffff_f000);
    queue_req(OP_ALLOC, '0, '0);
    queue_req(OP_FREE, 64'hffff_ffff_ffff_f000 + 64'h3000, '0);
    queue_req(OP_MARK_FREE, '0, 48'(10) << PAGE_SHIFT);

    // One tracked page, the largest offset: only page 0 exists.
    drain();
    write_cfg(CFG_TOTAL_PAGES, CFG_DATA_W'(1));
    write_cfg(CFG_BASE_OFFSET, '1);
    queue_req(OP_ALLOC, '0, '0);
    queue_req(OP_FREE, '1, '0);
    queue_req(OP_FREE, 64'h1000, '0);

    // Random part across several settings, the full bitmap among them.
    run_phase(TOTAL_W'(256), '0, 300);
    run_phase(TOTAL_W'(100), {$urandom, $urandom}, 300);
    run_phase(TOTAL_W'(32), 64'hffff_ffff_ffff_f000, 300);
    run_phase(TOTAL_W'(512), {$urandom, $urandom}, 300);
    run_phase(TOTAL_W'(33), 64'($urandom_range(0, 1 << 20)), 300);
    run_phase(TOTAL_W'(200), 64'd1, 300);
    run_phase(TOTAL_W'(MAX_PAGES), '0, 60);
    run_phase(TOTAL_W'(64), {$urandom, $urandom}, 140);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_resps.size() == 0) begin
      $display("tb_bitmap_page_allocator: PASS");
    end else begin
      $display("tb_bitmap_page_allocator: FAIL");
    end
    $finish;
  end

endmodule

[bitmap_page_allocator.f]
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_datapath.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/bitmap_page_allocator.sv
hw/rtl/bpa_checker.sv
tb/sv/tb_bitmap_page_allocator.sv
